// File: rtl/core/bcm_pkg.sv
// ============================================================================
// bcm_pkg
// Shared types, codes and the bit-count function of the correlation memory.
// ============================================================================
`default_nettype none

package bcm_pkg;

  localparam int MAX_W   = 64;  // width of the mask fields on the ports
  localparam int LABEL_W = 4;
  localparam int CNT_W   = 13;
  localparam int POP_W   = 7;   // bits of one row count, up to MAX_W

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic               op;
    logic [MAX_W-1:0]   first_active;
    logic [MAX_W-1:0]   second_active;
    logic [LABEL_W-1:0] label;
  } bcm_in_t;

  typedef struct packed {
    logic [LABEL_W-1:0] class_index;
    logic [CNT_W-1:0]   bit_count;
    logic               last;
  } bcm_out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_EMIT
  } bcm_state_t;

  // Control of the shared count unit.
  typedef struct packed {
    logic clr;  // start a new count from zero
    logic add;  // add the count of the current row
    logic inv;  // count bits clear in the row instead of set
  } bcm_cnt_ctl_t;

  // Population count as a fixed tree of field additions.
  function automatic logic [POP_W-1:0] pop64(input logic [MAX_W-1:0] x);
    logic [MAX_W-1:0] x1;
    logic [MAX_W-1:0] x2;
    logic [MAX_W-1:0] x3;
    logic [MAX_W-1:0] x4;
    logic [MAX_W-1:0] x5;
    logic [MAX_W-1:0] x6;
    x1 = x - ((x >> 1) & 64'h5555_5555_5555_5555);
    x2 = (x1 & 64'h3333_3333_3333_3333) + ((x1 >> 2) & 64'h3333_3333_3333_3333);
    x3 = (x2 + (x2 >> 4)) & 64'h0f0f_0f0f_0f0f_0f0f;
    x4 = x3 + (x3 >> 8);
    x5 = x4 + (x4 >> 16);
    x6 = x5 + (x5 >> 32);
    return x6[POP_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/bcm_count.sv
// ============================================================================
// bcm_count
// Shared count unit: counts the masked bits of one stored row per cycle and
// accumulates the result.
// ============================================================================
`default_nettype none

module bcm_count #(
  parameter int WIDTH = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire bcm_pkg::bcm_cnt_ctl_t     ctl,
  input  wire logic [WIDTH-1:0]          row,
  input  wire logic [WIDTH-1:0]          mask,
  output logic [bcm_pkg::CNT_W-1:0]      acc
);
  import bcm_pkg::*;

  logic [CNT_W-1:0] acc_r;
  logic [CNT_W-1:0] acc_nxt;
  logic [WIDTH-1:0] sel;
  logic [POP_W-1:0] pop;

  assign sel = ctl.inv ? ~row : row;
  assign pop = pop64(MAX_W'(mask & sel));

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (ctl.add) begin
      acc_nxt = acc_r + CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// File: rtl/core/binary_correlation_memory.sv
// ============================================================================
// binary_correlation_memory
// Bit store of (first, second, class) associations with write and per-class
// read counting, one stored row per cycle through a shared count unit.
// ============================================================================
//
//   channel   ports                          direction   carries
//   in        in_valid / in_ready / in_item  input       one operation
//   out       out_valid / out_ready / out_item output    one class count
//
// A write runs over the WIDTH rows of its label, and a write under a label
// beyond the classes runs none; a read runs over the rows of every class in
// turn. Rows go one per cycle through the single row read port.
// After reset a clearing pass zeroes all NUM_CLASSES * WIDTH rows, one a cycle.
// A result waits in the output register; while it is not taken the sequencer
// holds before loading the next one, and in_ready stays low until the last.
`default_nettype none

module binary_correlation_memory #(
  parameter int WIDTH       = 64,
  parameter int NUM_CLASSES = 10
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bcm_pkg::bcm_in_t   in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bcm_pkg::bcm_out_t       out_item
);
  import bcm_pkg::*;

  localparam int ROWS   = NUM_CLASSES * WIDTH;
  localparam int ADDR_W = $clog2(ROWS);
  localparam int J_W    = $clog2(WIDTH);
  localparam int CLS_W  = $clog2(NUM_CLASSES);

  bcm_state_t state_r, state_nxt;

  logic               op_r, op_nxt;
  logic [WIDTH-1:0]   first_r, first_nxt;
  logic [WIDTH-1:0]   second_r, second_nxt;
  logic [LABEL_W-1:0] label_r, label_nxt;
  logic [CLS_W-1:0]   cls_r, cls_nxt;
  logic [J_W-1:0]     j_r, j_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [ADDR_W-1:0]  wr_addr_r, wr_addr_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [WIDTH-1:0]   rd_data_r;
  logic               out_valid_r, out_valid_nxt;
  bcm_out_t           out_r, out_nxt;

  logic               accept;
  logic               label_ok;
  logic               rd_en;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [WIDTH-1:0]   mem_wd;
  logic               emit_go;
  logic               last_cls;
  bcm_cnt_ctl_t       cnt_ctl;
  logic [CNT_W-1:0]   cnt_acc;

  logic [WIDTH-1:0]   mem [ROWS];

  assign accept   = in_valid && in_ready;
  assign label_ok = 5'(in_item.label) < 5'(NUM_CLASSES);
  assign emit_go  = !out_valid_r || out_ready;
  assign last_cls = cls_r == CLS_W'(NUM_CLASSES - 1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (addr_r == ADDR_W'(ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_item.op == OP_READ || label_ok) begin
            state_nxt = S_RUN;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_RUN: begin
        if (j_r == J_W'(WIDTH - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) begin
          if (op_r == OP_READ && !last_cls) begin
            state_nxt = S_RUN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath control.
  always_comb begin
    op_nxt        = op_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    label_nxt     = label_r;
    cls_nxt       = cls_r;
    j_nxt         = j_r;
    addr_nxt      = addr_r;
    wr_addr_nxt   = wr_addr_r;
    rd_vld_nxt    = 1'b0;
    rd_en         = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    in_ready      = 1'b0;
    cnt_ctl       = '0;

    // Row data read in the previous cycle for a set second bit is counted
    // and, on a write, merged back; the write-back never hits the row read now.
    if (rd_vld_r) begin
      cnt_ctl.add = 1'b1;
      cnt_ctl.inv = op_r == OP_WRITE;
    end
    mem_we = rd_vld_r && op_r == OP_WRITE;
    mem_wa = wr_addr_r;
    mem_wd = rd_data_r | first_r;

    case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_wa   = addr_r;
        mem_wd   = '0;
        addr_nxt = addr_r + 1'b1;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          op_nxt      = in_item.op;
          first_nxt   = in_item.first_active[WIDTH-1:0];
          second_nxt  = in_item.second_active[WIDTH-1:0];
          label_nxt   = in_item.label;
          cls_nxt     = '0;
          j_nxt       = '0;
          cnt_ctl.clr = 1'b1;
          if (in_item.op == OP_READ) begin
            addr_nxt = '0;
          end else begin
            addr_nxt = ADDR_W'(32'(in_item.label) * WIDTH);
          end
        end
      end
      S_RUN: begin
        rd_en       = 1'b1;
        rd_vld_nxt  = second_r[j_r];
        wr_addr_nxt = addr_r;
        addr_nxt    = addr_r + 1'b1;
        j_nxt       = (j_r == J_W'(WIDTH - 1)) ? '0 : j_r + 1'b1;
      end
      S_DRAIN: begin
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          cnt_ctl.clr   = 1'b1;
          out_nxt.bit_count = cnt_acc;
          if (op_r == OP_READ) begin
            out_nxt.class_index = LABEL_W'(cls_r);
            out_nxt.last        = last_cls;
            cls_nxt             = last_cls ? cls_r : cls_r + 1'b1;
          end else begin
            out_nxt.class_index = label_r;
            out_nxt.last        = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    first_r   <= first_nxt;
    second_r  <= second_nxt;
    label_r   <= label_nxt;
    cls_r     <= cls_nxt;
    j_r       <= j_nxt;
    wr_addr_r <= wr_addr_nxt;
    out_r     <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr_r];
    end
  end

  bcm_count #(
    .WIDTH (WIDTH)
  ) u_count (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cnt_ctl),
    .row   (rd_data_r),
    .mask  (first_r),
    .acc   (cnt_acc)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // No row read may still be in flight once the block is ready again.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !rd_vld_r)
    else $error("row data pending while ready");

  // A write under a label beyond the classes reports a zero count.
  a_bad_label_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.op == OP_WRITE && !label_ok) |=> cnt_acc == '0)
    else $error("out-of-range label produced a nonzero count");

  // No single class count covers more than every pair once.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_acc) <= WIDTH * WIDTH)
    else $error("count exceeds the number of pairs");

  // The count unit is only fed during a run or its drain cycle.
  a_add_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_ctl.add |-> (state_r == S_RUN || state_r == S_DRAIN))
    else $error("row counted outside a run");

endmodule

`default_nettype wire

// File: tb/binary_correlation_memory_chk.sv
// ============================================================================
// binary_correlation_memory_chk
// Watches both channels of the correlation memory and keeps its own copy of
// the association store. Every accepted item is turned into the counts it
// must produce. Each accepted result is compared field by field with the
// oldest count still due.
// ============================================================================
`timescale 1ns / 1ps

module binary_correlation_memory_chk #(
  parameter int WIDTH       = 64,
  parameter int NUM_CLASSES = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  bcm_pkg::bcm_in_t  in_item,
  input  logic              out_valid,
  input  logic              out_ready,
  input  bcm_pkg::bcm_out_t out_item,
  output int                fail_count,
  output int                pending
);
  import bcm_pkg::*;

  // Row c * WIDTH + j holds, in bit i, the pair (i, j) of class c.
  logic [MAX_W-1:0] assoc_rows [NUM_CLASSES*WIDTH];
  bcm_out_t         counts_due [$];

  function automatic void predict_counts(input bcm_in_t op_item);
    logic [MAX_W-1:0] lanes;
    logic [MAX_W-1:0] first;
    logic [MAX_W-1:0] second;
    int               row;
    int               total;
    bcm_out_t         res;
    lanes  = '1;
    lanes  = lanes >> (MAX_W - WIDTH);
    first  = op_item.first_active & lanes;
    second = op_item.second_active & lanes;
    if (op_item.op == OP_WRITE) begin
      total = 0;
      // A label beyond the classes stores nothing but still reports.
      if (op_item.label < NUM_CLASSES) begin
        for (int j = 0; j < WIDTH; j++) begin
          if (second[j]) begin
            row = int'(op_item.label) * WIDTH + j;
            total += $countones(first & ~assoc_rows[row]);
            assoc_rows[row] |= first;
          end
        end
      end
      res.class_index = op_item.label;
      res.bit_count   = total[CNT_W-1:0];
      res.last        = 1'b1;
      counts_due.push_back(res);
    end else begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        total = 0;
        for (int j = 0; j < WIDTH; j++) begin
          if (second[j]) begin
            total += $countones(first & assoc_rows[c*WIDTH+j]);
          end
        end
        res.class_index = c[LABEL_W-1:0];
        res.bit_count   = total[CNT_W-1:0];
        res.last        = (c == NUM_CLASSES - 1);
        counts_due.push_back(res);
      end
    end
  endfunction

  always @(posedge clk) begin
    bcm_out_t want;
    if (!rst_n) begin
      foreach (assoc_rows[r]) assoc_rows[r] = '0;
      counts_due.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_counts(in_item);
      end
      if (out_valid && out_ready) begin
        if (counts_due.size() == 0) begin
          $error("unexpected result: class_index %0d bit_count %0d last %0d",
                 out_item.class_index, out_item.bit_count, out_item.last);
          fail_count++;
        end else begin
          want = counts_due.pop_front();
          if (out_item.class_index !== want.class_index) begin
            $error("class_index expected %0d actual %0d",
                   want.class_index, out_item.class_index);
            fail_count++;
          end
          if (out_item.bit_count !== want.bit_count) begin
            $error("bit_count expected %0d actual %0d",
                   want.bit_count, out_item.bit_count);
            fail_count++;
          end
          if (out_item.last !== want.last) begin
            $error("last expected %0d actual %0d", want.last, out_item.last);
            fail_count++;
          end
        end
      end
    end
    pending = counts_due.size();
  end

endmodule

// File: tb/binary_correlation_memory_tb.sv
// ============================================================================
// binary_correlation_memory_tb
// Drives write and read items into the correlation memory: a directed run
// over the mask extremes, saturation and labels beyond the classes, then
// random writes mixed with reads mostly of recent patterns, with random
// idle bursts on both channels. A checker instance predicts and compares.
// ============================================================================
`timescale 1ns / 1ps

module binary_correlation_memory_tb;
  import bcm_pkg::*;

  localparam int WIDTH        = 64;
  localparam int NUM_CLASSES  = 10;
  localparam int CLK_PERIOD   = 12;
  localparam int RANDOM_OPS   = 190;
  localparam int QUIET_OPS    = 30;
  localparam int TAIL_CYCLES  = 40;
  localparam int LIMIT_CYCLES = 2_000_000;

  logic     clk        = 1'b0;
  logic     rst_n      = 1'b0;
  logic     in_valid   = 1'b0;
  logic     in_ready;
  bcm_in_t  in_item    = '0;
  logic     out_valid;
  logic     out_ready  = 1'b0;
  bcm_out_t out_item;
  int       fail_count;
  int       pending;
  logic     quiet      = 1'b0;
  int       ready_hold = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  binary_correlation_memory #(
    .WIDTH      (WIDTH),
    .NUM_CLASSES(NUM_CLASSES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  binary_correlation_memory_chk #(
    .WIDTH      (WIDTH),
    .NUM_CLASSES(NUM_CLASSES)
  ) i_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // The result side takes or refuses in bursts of random length.
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready  <= ($urandom_range(0, 2) != 0);
      ready_hold <= $urandom_range(0, 15);
    end
  end

  function automatic bcm_in_t make_op(input logic op, input logic [MAX_W-1:0] first,
                                      input logic [MAX_W-1:0] second,
                                      input logic [LABEL_W-1:0] lbl);
    bcm_in_t it;
    it.op            = op;
    it.first_active  = first;
    it.second_active = second;
    it.label         = lbl;
    return it;
  endfunction

  function automatic logic [MAX_W-1:0] pick_mask();
    logic [MAX_W-1:0] m;
    case ($urandom_range(0, 9))
      0: begin
        m = '0;
      end
      1: begin
        m = '1;
      end
      2, 3, 4: begin
        m = {$urandom, $urandom};
      end
      default: begin
        m = '0;
        repeat ($urandom_range(1, 6)) m[$urandom_range(0, MAX_W-1)] = 1'b1;
      end
    endcase
    return m;
  endfunction

  // Valid drops only when an idle burst is taken, so back-to-back items keep
  // it high across the accepting edge.
  task automatic send_op(input bcm_in_t it);
    int gap;
    if (!quiet && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    logic [MAX_W-1:0]   recent_first  [4];
    logic [MAX_W-1:0]   recent_second [4];
    logic [MAX_W-1:0]   first;
    logic [MAX_W-1:0]   second;
    logic [LABEL_W-1:0] lbl;
    int                 slot;
    int                 op_pick;
    foreach (recent_first[k]) begin
      recent_first[k]  = pick_mask();
      recent_second[k] = pick_mask();
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty store, single and full rows, saturation,
    // labels beyond the classes and reads that ignore the label.
    send_op(make_op(OP_READ,  '1, '1, 4'hf));
    send_op(make_op(OP_WRITE, '0, '0, 4'h0));
    send_op(make_op(OP_WRITE, '1, 64'h1, 4'h0));
    send_op(make_op(OP_WRITE, '1, 64'h1, 4'h0));
    send_op(make_op(OP_WRITE, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 4'h9));
    send_op(make_op(OP_WRITE, '1, '1, 4'h9));
    for (int l = NUM_CLASSES; l < 16; l++) begin
      send_op(make_op(OP_WRITE, '1, '1, l[LABEL_W-1:0]));
    end
    send_op(make_op(OP_READ,  '1, '1, 4'h0));
    send_op(make_op(OP_READ,  '0, '1, 4'ha));
    send_op(make_op(OP_WRITE, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 4'h5));
    send_op(make_op(OP_READ,  64'h5555_5555_5555_5555, '1, 4'h7));
    send_op(make_op(OP_WRITE, 64'h8000_0000_0000_0001, 64'h1, 4'h3));
    send_op(make_op(OP_READ,  '1, 64'h1, 4'h3));
    send_op(make_op(OP_READ,  '1, '0, 4'h5));

    // Random part: mostly writes, with reads that mostly revisit recently written
    // patterns so that the counts are not trivially zero.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == RANDOM_OPS - QUIET_OPS) quiet <= 1'b1;
      slot    = $urandom_range(0, 3);
      op_pick = $urandom_range(0, 99);
      if (op_pick < 60) begin
        if ($urandom_range(0, 11) == 0) begin
          lbl = 4'($urandom_range(NUM_CLASSES, 15));
        end else begin
          lbl = 4'($urandom_range(0, NUM_CLASSES - 1));
        end
        first  = pick_mask();
        second = pick_mask();
        recent_first[slot]  = first;
        recent_second[slot] = second;
        send_op(make_op(OP_WRITE, first, second, lbl));
      end else begin
        if (op_pick < 85) begin
          first  = recent_first[slot];
          second = recent_second[slot];
          if ($urandom_range(0, 1) == 0) second = second | pick_mask();
        end else begin
          first  = pick_mask();
          second = pick_mask();
        end
        send_op(make_op(OP_READ, first, second, 4'($urandom_range(0, 15))));
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS binary_correlation_memory");
    end else begin
      $display("FAIL binary_correlation_memory");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("FAIL binary_correlation_memory");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/bcm_pkg.sv
rtl/core/bcm_count.sv
rtl/core/binary_correlation_memory.sv
tb/binary_correlation_memory_chk.sv
tb/binary_correlation_memory_tb.sv
